[src/qppmd_pkg.sv]
// ----------------------------------------------------------------------------
// qppmd_pkg
// Shared types, widths and constants of the four-channel positional PID drive.
// ----------------------------------------------------------------------------
package qppmd_pkg;

   // channel count and position width; the datapath depth covers four channels
   localparam int CHANNELS   = 4;
   localparam int CH_W       = $clog2(CHANNELS);
   localparam int POS_WIDTH  = 32;

   // field widths
   localparam int DELTA_W    = 16;
   localparam int TARGET_W   = 32;
   localparam int GAIN_W     = 16;
   localparam int MAG_W      = 16;
   localparam int INTEG_W    = 18;
   localparam int ERR_W      = POS_WIDTH + 1;
   localparam int ISUM_W     = ERR_W + 1;
   localparam int DIFF_W     = POS_WIDTH + 2;
   localparam int FRAC_BITS  = 8;

   // product and sum widths (signed operand times 17-bit signed gain)
   localparam int P_W        = ERR_W + GAIN_W + 1;
   localparam int I_W        = INTEG_W + GAIN_W + 1;
   localparam int D_W        = DIFF_W + GAIN_W + 1;
   localparam int SUM_W      = D_W + 2;
   localparam int MAGF_W     = SUM_W - FRAC_BITS;

   // result queue
   localparam int RESULT_DEPTH = 4;
   localparam int RQ_PTR_W     = $clog2(RESULT_DEPTH);
   localparam int RQ_CNT_W     = $clog2(RESULT_DEPTH + 1);

   // register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [GAIN_W-1:0] KP_RESET   = 16'd256;
   localparam logic [GAIN_W-1:0] KI_RESET   = 16'd0;
   localparam logic [GAIN_W-1:0] KD_RESET   = 16'd256;
   localparam logic [GAIN_W-1:0] ILIM_RESET = 16'd3000;
   localparam logic [GAIN_W-1:0] OLIM_RESET = 16'd6900;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP   = 3'd0,
      CSR_KI   = 3'd1,
      CSR_KD   = 3'd2,
      CSR_ILIM = 3'd3,
      CSR_OLIM = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0]  delta_a;
      logic signed [DELTA_W-1:0]  delta_b;
      logic signed [DELTA_W-1:0]  delta_c;
      logic signed [DELTA_W-1:0]  delta_d;
      logic signed [TARGET_W-1:0] target_a;
      logic signed [TARGET_W-1:0] target_b;
      logic signed [TARGET_W-1:0] target_c;
      logic signed [TARGET_W-1:0] target_d;
   } req_payload_type;

   typedef struct packed {
      logic             dir_port_a;
      logic [MAG_W-1:0] mag_port_a;
      logic             dir_port_b;
      logic [MAG_W-1:0] mag_port_b;
      logic             dir_port_c;
      logic [MAG_W-1:0] mag_port_c;
      logic             dir_port_d;
      logic [MAG_W-1:0] mag_port_d;
   } rsp_payload_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp_gain;
      logic [GAIN_W-1:0] ki_gain;
      logic [GAIN_W-1:0] kd_gain;
      logic [GAIN_W-1:0] integral_limit;
      logic [GAIN_W-1:0] output_limit;
   } gains_type;

   // one channel handed to the datapath
   typedef struct packed {
      logic                       valid;
      logic [CH_W-1:0]            ch;
      logic signed [DELTA_W-1:0]  delta;
      logic signed [TARGET_W-1:0] target;
   } issue_type;

   // one channel drive coming back
   typedef struct packed {
      logic             valid;
      logic [CH_W-1:0]  port;
      logic             last;
      logic             dir;
      logic [MAG_W-1:0] mag;
   } chan_result_type;

   // per-channel state word
   typedef struct packed {
      logic signed [POS_WIDTH-1:0] pos;
      logic signed [INTEG_W-1:0]   integ;
      logic signed [ERR_W-1:0]     last_err;
   } state_type;

   // ports a and b carry channels b and a
   function automatic logic [CH_W-1:0] port_of(input logic [CH_W-1:0] ch);
      logic [CH_W-1:0] port;
      if (CHANNELS >= 2 && ch < CH_W'(2)) begin
         port = ch ^ CH_W'(1);
      end else begin
         port = ch;
      end
      return port;
   endfunction

endpackage

[src/qppmd_chan_pipe.sv]
// ----------------------------------------------------------------------------
// qppmd_chan_pipe
// Shared per-channel PID datapath around the channel state memory: read,
// position update, error, clamped integral, write back, gain products, sum,
// truncation and output clamp. One channel enters per cycle.
// ----------------------------------------------------------------------------
module qppmd_chan_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  qppmd_pkg::issue_type       issue,
   input  qppmd_pkg::gains_type       gains,
   output qppmd_pkg::chan_result_type result
);
   import qppmd_pkg::*;

   // channel state memory and its per-entry valid bits
   state_type             mem [CHANNELS];
   logic [CHANNELS-1:0]   ent_valid_ff;
   state_type             rd_ff;
   logic                  rd_ok_ff;
   state_type             wr_entry;
   logic                  fwd_hit;

   // stage valids
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s5_valid_ff, s6_valid_ff, s7_valid_ff, res_valid_ff;

   // stage payloads
   logic [CH_W-1:0]             s1_ch_ff, s2_ch_ff, s3_ch_ff, s4_ch_ff;
   logic [CH_W-1:0]             s5_ch_ff, s6_ch_ff, s7_ch_ff;
   logic signed [DELTA_W-1:0]   s1_delta_ff;
   logic signed [TARGET_W-1:0]  s1_target_ff, s2_target_ff;
   logic signed [POS_WIDTH-1:0] s2_pos_ff, s3_pos_ff;
   logic signed [INTEG_W-1:0]   s2_integ_ff, s3_integ_ff, s4_integ_ff;
   logic signed [ERR_W-1:0]     s2_last_err_ff, s3_last_err_ff;
   logic signed [ERR_W-1:0]     s3_err_ff, s4_err_ff;
   logic signed [DIFF_W-1:0]    s4_diff_ff;
   logic signed [P_W-1:0]       s5_p_ff;
   logic signed [I_W-1:0]       s5_i_ff;
   logic signed [D_W-1:0]       s5_d_ff;
   logic signed [SUM_W-1:0]     s6_sum_ff;
   logic                        s7_neg_ff;
   logic [MAGF_W-1:0]           s7_mag_ff;
   logic [CH_W-1:0]             res_port_ff;
   logic                        res_last_ff;
   logic                        res_dir_ff;
   logic [MAG_W-1:0]            res_mag_ff;

   // combinational next values
   state_type                   cur;
   logic signed [POS_WIDTH-1:0] pos_in;
   logic signed [ERR_W-1:0]     err_in;
   logic signed [ISUM_W-1:0]    isum;
   logic signed [ISUM_W-1:0]    ilim;
   logic signed [INTEG_W-1:0]   integ_in;
   logic signed [DIFF_W-1:0]    diff_in;
   logic signed [P_W-1:0]       p_in;
   logic signed [I_W-1:0]       i_in;
   logic signed [D_W-1:0]       d_in;
   logic signed [SUM_W-1:0]     sum_in;
   logic                        neg_in;
   logic [SUM_W-1:0]            abs_sum;
   logic [MAGF_W-1:0]           mag_in;
   logic [MAG_W-1:0]            mag_fin_in;
   logic                        dir_in;

   // write-back word and bypass of a same-entry write
   assign wr_entry = '{pos: s3_pos_ff, integ: integ_in, last_err: s3_err_ff};
   assign fwd_hit  = s3_valid_ff && (s3_ch_ff == issue.ch);

   // state memory: write at stage 3, registered read at issue
   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         mem[s3_ch_ff] <= wr_entry;
      end
      rd_ff <= fwd_hit ? wr_entry : mem[issue.ch];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         if (s3_valid_ff) begin
            ent_valid_ff[s3_ch_ff] <= 1'b1;
         end
         rd_ok_ff <= ent_valid_ff[issue.ch] || fwd_hit;
      end
   end

   // stage 1: position update, unwritten entries read as zero
   always_comb begin
      cur    = rd_ok_ff ? rd_ff : '0;
      pos_in = cur.pos + POS_WIDTH'(s1_delta_ff);
   end

   // stage 2: error at full width
   assign err_in = ERR_W'(s2_target_ff) - ERR_W'(s2_pos_ff);

   // stage 3: clamped integral and error difference
   always_comb begin
      isum = ISUM_W'(s3_integ_ff) + ISUM_W'(s3_err_ff);
      ilim = $signed(ISUM_W'(gains.integral_limit));
      if (isum > ilim) begin
         integ_in = INTEG_W'(ilim);
      end else if (isum < -ilim) begin
         integ_in = INTEG_W'(-ilim);
      end else begin
         integ_in = INTEG_W'(isum);
      end
      diff_in = DIFF_W'(s3_err_ff) - DIFF_W'(s3_last_err_ff);
   end

   // stage 4: gain products
   assign p_in = s4_err_ff  * $signed({1'b0, gains.kp_gain});
   assign i_in = s4_integ_ff * $signed({1'b0, gains.ki_gain});
   assign d_in = s4_diff_ff * $signed({1'b0, gains.kd_gain});

   // stage 5: sum of terms
   assign sum_in = SUM_W'(s5_p_ff) + SUM_W'(s5_i_ff) + SUM_W'(s5_d_ff);

   // stage 6: magnitude, truncated toward zero
   always_comb begin
      neg_in  = s6_sum_ff[SUM_W-1];
      abs_sum = neg_in ? SUM_W'(-s6_sum_ff) : SUM_W'(s6_sum_ff);
      mag_in  = abs_sum[SUM_W-1:FRAC_BITS];
   end

   // stage 7: output clamp and direction
   always_comb begin
      if (s7_mag_ff > MAGF_W'(gains.output_limit)) begin
         mag_fin_in = gains.output_limit;
      end else begin
         mag_fin_in = s7_mag_ff[MAG_W-1:0];
      end
      dir_in = !s7_neg_ff && (mag_fin_in != '0);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= issue.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         res_valid_ff <= s7_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      s1_ch_ff       <= issue.ch;
      s1_delta_ff    <= issue.delta;
      s1_target_ff   <= issue.target;

      s2_ch_ff       <= s1_ch_ff;
      s2_target_ff   <= s1_target_ff;
      s2_pos_ff      <= pos_in;
      s2_integ_ff    <= cur.integ;
      s2_last_err_ff <= cur.last_err;

      s3_ch_ff       <= s2_ch_ff;
      s3_pos_ff      <= s2_pos_ff;
      s3_err_ff      <= err_in;
      s3_integ_ff    <= s2_integ_ff;
      s3_last_err_ff <= s2_last_err_ff;

      s4_ch_ff       <= s3_ch_ff;
      s4_err_ff      <= s3_err_ff;
      s4_integ_ff    <= integ_in;
      s4_diff_ff     <= diff_in;

      s5_ch_ff       <= s4_ch_ff;
      s5_p_ff        <= p_in;
      s5_i_ff        <= i_in;
      s5_d_ff        <= d_in;

      s6_ch_ff       <= s5_ch_ff;
      s6_sum_ff      <= sum_in;

      s7_ch_ff       <= s6_ch_ff;
      s7_neg_ff      <= neg_in;
      s7_mag_ff      <= mag_in;

      res_port_ff    <= port_of(s7_ch_ff);
      res_last_ff    <= (s7_ch_ff == CH_W'(CHANNELS - 1));
      res_dir_ff     <= dir_in;
      res_mag_ff     <= mag_fin_in;
   end

   assign result = '{valid: res_valid_ff, port: res_port_ff, last: res_last_ff,
                     dir: res_dir_ff, mag: res_mag_ff};

endmodule

[src/quad_position_pid_motor_drive.sv]
// ----------------------------------------------------------------------------
// quad_position_pid_motor_drive
// Four-channel positional PID drive with integral clamp: per tick, channel
// state is read from a small state memory, updated and written back, and the
// four clamped drives are packed into one result beat.
// ----------------------------------------------------------------------------
// throughput: one channel per cycle through the shared datapath and the single state
//   memory port; a new item may enter while the last channel of the previous one issues
// reset: clears control and the state-memory valid bits and loads the gain registers
//   with their reset values; no clearing pass, an item may enter in the first cycle after reset
// ----------------------------------------------------------------------------
module quad_position_pid_motor_drive (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  qppmd_pkg::req_payload_type           req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output qppmd_pkg::rsp_payload_type           rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [qppmd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qppmd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import qppmd_pkg::*;

   gains_type                  gains_ff;

   // channel sequencer
   logic                       active_ff;
   logic [CH_W-1:0]            ch_ff;
   req_payload_type            item_ff;
   logic                       last_issue;
   logic                       can_take;
   logic                       accept;
   logic signed [DELTA_W-1:0]  deltas  [CHANNELS];
   logic signed [TARGET_W-1:0] targets [CHANNELS];
   issue_type                  issue;
   chan_result_type            result;

   // items in flight and result queue
   logic [RQ_CNT_W-1:0]        count_ff, count_in;
   logic [RQ_CNT_W-1:0]        fifo_cnt_ff, fifo_cnt_in;
   logic [RQ_PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   rsp_payload_type            fifo_mem [RESULT_DEPTH];
   logic                       push;
   logic                       pop;

   // result assembly per port
   logic                       asm_dir_ff [CHANNELS];
   logic [MAG_W-1:0]           asm_mag_ff [CHANNELS];
   logic                       asm_dir_in [CHANNELS];
   logic [MAG_W-1:0]           asm_mag_in [CHANNELS];
   rsp_payload_type            push_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kp_gain        <= KP_RESET;
         gains_ff.ki_gain        <= KI_RESET;
         gains_ff.kd_gain        <= KD_RESET;
         gains_ff.integral_limit <= ILIM_RESET;
         gains_ff.output_limit   <= OLIM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KP:   gains_ff.kp_gain        <= csr_wdata;
            CSR_KI:   gains_ff.ki_gain        <= csr_wdata;
            CSR_KD:   gains_ff.kd_gain        <= csr_wdata;
            CSR_ILIM: gains_ff.integral_limit <= csr_wdata;
            CSR_OLIM: gains_ff.output_limit   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // take a new beat while the last channel of the previous one issues
   assign last_issue = active_ff && (ch_ff == CH_W'(CHANNELS - 1));
   assign can_take   = (!active_ff || last_issue) && (count_ff < RQ_CNT_W'(RESULT_DEPTH));
   assign req_stall  = !can_take;
   assign accept     = req_valid && can_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ch_ff     <= '0;
      end else if (accept) begin
         active_ff <= 1'b1;
         ch_ff     <= '0;
      end else if (last_issue) begin
         active_ff <= 1'b0;
         ch_ff     <= '0;
      end else if (active_ff) begin
         ch_ff     <= ch_ff + CH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   // channel select for the datapath
   always_comb begin
      deltas[0]    = item_ff.delta_a;
      deltas[1]    = item_ff.delta_b;
      deltas[2]    = item_ff.delta_c;
      deltas[3]    = item_ff.delta_d;
      targets[0]   = item_ff.target_a;
      targets[1]   = item_ff.target_b;
      targets[2]   = item_ff.target_c;
      targets[3]   = item_ff.target_d;
      issue.valid  = active_ff;
      issue.ch     = ch_ff;
      issue.delta  = deltas[ch_ff];
      issue.target = targets[ch_ff];
   end

   qppmd_chan_pipe u_pipe (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .gains  (gains_ff),
      .result (result)
   );

   // merge the returning channel into the assembly
   always_comb begin
      for (int p = 0; p < CHANNELS; p++) begin
         asm_dir_in[p] = asm_dir_ff[p];
         asm_mag_in[p] = asm_mag_ff[p];
      end
      if (result.valid) begin
         asm_dir_in[result.port] = result.dir;
         asm_mag_in[result.port] = result.mag;
      end
      push_data.dir_port_a = asm_dir_in[0];
      push_data.mag_port_a = asm_mag_in[0];
      push_data.dir_port_b = asm_dir_in[1];
      push_data.mag_port_b = asm_mag_in[1];
      push_data.dir_port_c = asm_dir_in[2];
      push_data.mag_port_c = asm_mag_in[2];
      push_data.dir_port_d = asm_dir_in[3];
      push_data.mag_port_d = asm_mag_in[3];
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < CHANNELS; p++) begin
         asm_dir_ff[p] <= asm_dir_in[p];
         asm_mag_ff[p] <= asm_mag_in[p];
      end
   end

   // result queue
   assign push      = result.valid && result.last;
   assign rsp_valid = (fifo_cnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = fifo_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
   end

   // counts: items accepted but not yet delivered, and queued results
   always_comb begin
      count_in    = count_ff;
      fifo_cnt_in = fifo_cnt_ff;
      if (accept) begin
         count_in = count_in + RQ_CNT_W'(1);
      end
      if (pop) begin
         count_in    = count_in - RQ_CNT_W'(1);
         fifo_cnt_in = fifo_cnt_in - RQ_CNT_W'(1);
      end
      if (push) begin
         fifo_cnt_in = fifo_cnt_in + RQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         fifo_cnt_ff <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
      end else begin
         count_ff    <= count_in;
         fifo_cnt_ff <= fifo_cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RQ_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RQ_PTR_W'(1);
         end
      end
   end

`ifndef ASSERT_OFF
   // never more beats in flight than the result queue can hold
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= RQ_CNT_W'(RESULT_DEPTH))
      else $error("items in flight exceed result queue depth");

   // queued results always belong to accepted beats
   assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= count_ff)
      else $error("more queued results than beats in flight");

   // a completed result never lands on a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_cnt_ff < RQ_CNT_W'(RESULT_DEPTH)))
      else $error("result pushed into a full queue");

   // the sequencer goes idle after the last channel unless a new beat arrives
   assert property (@(posedge clock) disable iff (reset)
      (last_issue && !accept) |=> !active_ff)
      else $error("sequencer kept running past the last channel");
`endif

endmodule

[tb/sv/quad_position_pid_motor_drive_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quad_position_pid_motor_drive_test
// Drives control ticks into the four-channel PID drive under random sender
// and receiver idling, predicts every drive beat with an in-bench model of
// the position, integral and derivative state, and checks each result beat
// field by field. Gains and limits are swept between phases, including the
// extremes, a lowered integral clamp, zero limits and full-rate travel at the
// largest deltas.
// ----------------------------------------------------------------------------
module quad_position_pid_motor_drive_test;
   import qppmd_pkg::*;

   localparam int LONG_HOLD      = 500;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_PHASES  = 6;
   localparam int RANDOM_TICKS   = 960;
   localparam int WRAP_TICKS     = 120;

   localparam logic [CSR_IDX_W-1:0]   CSR_UNUSED = 3'd7;
   localparam logic signed [TARGET_W-1:0] TARGET_MAX = 32'sh7fffffff;
   localparam logic signed [TARGET_W-1:0] TARGET_MIN = 32'sh80000000;
   localparam logic signed [DELTA_W-1:0]  DELTA_MAX  = 16'sh7fff;
   localparam logic signed [DELTA_W-1:0]  DELTA_MIN  = 16'sh8000;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // ticks waiting to be offered and drive beats waiting to come back
   req_payload_type tick_queue [$];
   rsp_payload_type expected_drives [$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_token    = 0;
   int  error_count   = 0;
   int  quiet_cycles  = 0;
   logic req_fire     = 1'b0;

   // predicted gains and channel state
   logic [GAIN_W-1:0]           cfg_kp   = KP_RESET;
   logic [GAIN_W-1:0]           cfg_ki   = KI_RESET;
   logic [GAIN_W-1:0]           cfg_kd   = KD_RESET;
   logic [GAIN_W-1:0]           cfg_ilim = ILIM_RESET;
   logic [GAIN_W-1:0]           cfg_olim = OLIM_RESET;
   logic signed [POS_WIDTH-1:0] pos_state      [CHANNELS] = '{default: '0};
   longint                      integ_state    [CHANNELS] = '{default: 0};
   longint                      last_err_state [CHANNELS] = '{default: 0};

   // position the stimulus expects each channel to reach, for near targets
   logic signed [POS_WIDTH-1:0] plan_pos [CHANNELS] = '{default: '0};

   quad_position_pid_motor_drive dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic longint clamp_sym(input longint x, input longint lim);
      longint r;
      r = x;
      if (x > lim) begin
         r = lim;
      end else if (x < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   // one control tick through the PID law; products stay far below 2^61 here,
   // so the longint sums never overflow
   function automatic rsp_payload_type compute_drive_beat(input req_payload_type tick);
      logic signed [DELTA_W-1:0]  dl [CHANNELS];
      logic signed [TARGET_W-1:0] tg [CHANNELS];
      logic                       dir_ch [CHANNELS];
      logic [MAG_W-1:0]           mag_ch [CHANNELS];
      longint                     err;
      longint                     acc;
      longint                     mag;
      longint                     drv;
      rsp_payload_type            beat;
      dl[0] = tick.delta_a;
      dl[1] = tick.delta_b;
      dl[2] = tick.delta_c;
      dl[3] = tick.delta_d;
      tg[0] = tick.target_a;
      tg[1] = tick.target_b;
      tg[2] = tick.target_c;
      tg[3] = tick.target_d;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         // position wraps at its own width
         pos_state[ch] = pos_state[ch] + dl[ch];
         err = longint'(tg[ch]) - longint'(pos_state[ch]);
         integ_state[ch] = clamp_sym(integ_state[ch] + err, longint'(cfg_ilim));
         acc = longint'(cfg_kp) * err
             + longint'(cfg_ki) * integ_state[ch]
             + longint'(cfg_kd) * (err - last_err_state[ch]);
         last_err_state[ch] = err;
         // shift the magnitude so the result truncates toward zero
         mag = ((acc < 0) ? -acc : acc) >> FRAC_BITS;
         drv = clamp_sym((acc < 0) ? -mag : mag, longint'(cfg_olim));
         dir_ch[ch] = (drv > 0);
         mag_ch[ch] = MAG_W'((drv < 0) ? -drv : drv);
      end
      // ports a and b are swapped against channels a and b
      beat.dir_port_a = dir_ch[1];
      beat.mag_port_a = mag_ch[1];
      beat.dir_port_b = dir_ch[0];
      beat.mag_port_b = mag_ch[0];
      beat.dir_port_c = dir_ch[2];
      beat.mag_port_c = mag_ch[2];
      beat.dir_port_d = dir_ch[3];
      beat.mag_port_d = mag_ch[3];
      return beat;
   endfunction

   // input driver: a new beat only once the previous one has gone
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= tick_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // accepted ticks feed the predictor
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_drives.push_back(compute_drive_beat(req_data));
      end
   end

   // receiver: random stall, or a long hold when one is requested
   always @(negedge clock) begin : receiver_proc
      int hold_served;
      int hold_left;
      if (hold_token != hold_served) begin
         hold_served = hold_token;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [MAG_W-1:0] want,
                              input logic [MAG_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin : monitor_proc
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drives.size() == 0) begin
            $error("drive beat arrived with no tick outstanding");
            error_count++;
         end else begin
            want = expected_drives.pop_front();
            check_field("dir_port_a", MAG_W'(want.dir_port_a), MAG_W'(rsp_data.dir_port_a));
            check_field("mag_port_a", want.mag_port_a, rsp_data.mag_port_a);
            check_field("dir_port_b", MAG_W'(want.dir_port_b), MAG_W'(rsp_data.dir_port_b));
            check_field("mag_port_b", want.mag_port_b, rsp_data.mag_port_b);
            check_field("dir_port_c", MAG_W'(want.dir_port_c), MAG_W'(rsp_data.dir_port_c));
            check_field("mag_port_c", want.mag_port_c, rsp_data.mag_port_c);
            check_field("dir_port_d", MAG_W'(want.dir_port_d), MAG_W'(rsp_data.dir_port_d));
            check_field("mag_port_d", want.mag_port_d, rsp_data.mag_port_d);
         end
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // queue one tick and track where the positions will be
   task automatic push_tick(input logic signed [DELTA_W-1:0] da,
                            input logic signed [DELTA_W-1:0] db,
                            input logic signed [DELTA_W-1:0] dc,
                            input logic signed [DELTA_W-1:0] dd,
                            input logic signed [TARGET_W-1:0] ta,
                            input logic signed [TARGET_W-1:0] tb,
                            input logic signed [TARGET_W-1:0] tc,
                            input logic signed [TARGET_W-1:0] td);
      req_payload_type tick;
      tick.delta_a  = da;
      tick.delta_b  = db;
      tick.delta_c  = dc;
      tick.delta_d  = dd;
      tick.target_a = ta;
      tick.target_b = tb;
      tick.target_c = tc;
      tick.target_d = td;
      plan_pos[0] = plan_pos[0] + da;
      plan_pos[1] = plan_pos[1] + db;
      plan_pos[2] = plan_pos[2] + dc;
      plan_pos[3] = plan_pos[3] + dd;
      tick_queue.push_back(tick);
   endtask

   // random tick: mostly small moves with targets near the position
   task automatic push_random_tick();
      logic signed [DELTA_W-1:0]  dl [CHANNELS];
      logic signed [TARGET_W-1:0] tg [CHANNELS];
      logic signed [POS_WIDTH-1:0] next_pos;
      int r;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         r = $urandom_range(99);
         if (r < 60) begin
            dl[ch] = DELTA_W'(int'($urandom_range(128)) - 64);
         end else if (r < 85) begin
            dl[ch] = DELTA_W'($urandom());
         end else begin
            dl[ch] = $urandom_range(1) ? DELTA_MAX : DELTA_MIN;
         end
         next_pos = plan_pos[ch] + dl[ch];
         r = $urandom_range(99);
         if (r < 55) begin
            tg[ch] = next_pos + (int'($urandom_range(4000)) - 2000);
         end else if (r < 80) begin
            tg[ch] = TARGET_W'($urandom());
         end else if (r < 90) begin
            tg[ch] = $urandom_range(1) ? TARGET_MAX : TARGET_MIN;
         end else begin
            tg[ch] = next_pos;
         end
      end
      push_tick(dl[0], dl[1], dl[2], dl[3], tg[0], tg[1], tg[2], tg[3]);
   endtask

   // full-rate travel at the largest deltas, targets near the new positions
   task automatic push_wrap_tick();
      logic signed [DELTA_W-1:0]  dl [CHANNELS];
      logic signed [TARGET_W-1:0] tg [CHANNELS];
      dl[0] = DELTA_MAX;
      dl[1] = DELTA_MAX;
      dl[2] = DELTA_MIN;
      dl[3] = DELTA_MIN;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if ($urandom_range(9) == 0) begin
            tg[ch] = TARGET_W'($urandom());
         end else begin
            tg[ch] = plan_pos[ch] + dl[ch] + (int'($urandom_range(600)) - 300);
         end
      end
      push_tick(dl[0], dl[1], dl[2], dl[3], tg[0], tg[1], tg[2], tg[3]);
   endtask

   // wait until no tick is queued, offered or outstanding
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (tick_queue.size() != 0 || req_valid || expected_drives.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_KP:   cfg_kp   = value;
         CSR_KI:   cfg_ki   = value;
         CSR_KD:   cfg_kd   = value;
         CSR_ILIM: cfg_ilim = value;
         CSR_OLIM: cfg_olim = value;
         default:  ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_gains(input logic [CSR_DATA_W-1:0] kp, input logic [CSR_DATA_W-1:0] ki,
                            input logic [CSR_DATA_W-1:0] kd, input logic [CSR_DATA_W-1:0] ilim,
                            input logic [CSR_DATA_W-1:0] olim);
      write_csr(CSR_KP, kp);
      write_csr(CSR_KI, ki);
      write_csr(CSR_KD, kd);
      write_csr(CSR_ILIM, ilim);
      write_csr(CSR_OLIM, olim);
   endtask

   // stimulus sequence
   initial begin
      int per_phase;
      while (reset) @(negedge clock);
      send_idle_pct = 32;
      recv_idle_pct = 61;

      // directed, reset gains: zero tick, extreme deltas and targets
      push_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      push_tick(DELTA_MAX, DELTA_MIN, 16'sd0, 16'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      push_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, TARGET_MAX, TARGET_MIN, TARGET_MAX, TARGET_MIN);
      push_tick(DELTA_MIN, DELTA_MAX, -16'sd1, 16'sd0, TARGET_MIN, TARGET_MAX, 32'sd0, -32'sd1);
      // on target: derivative term only, then nothing at all
      push_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, plan_pos[0], plan_pos[1], plan_pos[2],
                plan_pos[3]);
      push_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, plan_pos[0], plan_pos[1], plan_pos[2],
                plan_pos[3]);
      wait_idle();

      // a write to an unused index must change nothing
      write_csr(CSR_UNUSED, 16'hFFFF);
      push_tick(16'sd100, -16'sd100, 16'sd5, -16'sd5, plan_pos[0] + 150, plan_pos[1] - 150,
                plan_pos[2] - 40, plan_pos[3] + 40);
      wait_idle();

      // all gains and limits at their maximum
      set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_tick(DELTA_MAX, DELTA_MIN, DELTA_MAX, DELTA_MIN, TARGET_MIN, TARGET_MAX, TARGET_MAX,
                TARGET_MIN);
      push_tick(DELTA_MIN, DELTA_MAX, DELTA_MIN, DELTA_MAX, TARGET_MAX, TARGET_MIN, TARGET_MIN,
                TARGET_MAX);
      push_tick(16'sd1, -16'sd1, 16'sd0, 16'sd0, plan_pos[0] + 1, plan_pos[1] - 2,
                plan_pos[2] + 3, plan_pos[3]);
      wait_idle();

      // everything zero: zero drive regardless of error
      set_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      push_random_tick();
      push_random_tick();
      wait_idle();

      // integral only: saturate the integral, then lower its clamp
      set_gains(16'd0, 16'd256, 16'd0, 16'hFFFF, 16'hFFFF);
      repeat (5) begin
         push_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, plan_pos[0] + 20000, plan_pos[1] - 20000,
                   plan_pos[2] + 20000, plan_pos[3] - 20000);
      end
      wait_idle();
      write_csr(CSR_ILIM, 16'd5);
      repeat (2) begin
         push_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, plan_pos[0] + 1000, plan_pos[1] - 1000,
                   plan_pos[2] - 1000, plan_pos[3] + 1000);
      end
      wait_idle();

      // random phases over a spread of settings
      per_phase = RANDOM_TICKS / RANDOM_PHASES;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 2) begin
            send_idle_pct = 32;
            recv_idle_pct = 61;
         end else if (p < 4) begin
            send_idle_pct = 61;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (p)
            0: set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'($urandom()));
            1: set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: set_gains(16'($urandom_range(600)), 16'($urandom_range(600)),
                         16'($urandom_range(600)), 16'($urandom()), 16'hFFFF);
            3: set_gains(16'($urandom_range(300)), 16'($urandom_range(64)),
                         16'($urandom_range(300)), 16'hFFFF, 16'($urandom()));
            4: set_gains(16'($urandom_range(400)), 16'($urandom_range(400)),
                         16'($urandom_range(400)), 16'($urandom_range(40)), 16'hFFFF);
            default: set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'd0,
                               16'd0);
         endcase
         repeat (per_phase) push_random_tick();
         // long receiver hold while ticks keep coming, so the block backs up
         if (p == 1) begin
            @(posedge clock);
            hold_token++;
         end
         wait_idle();
      end

      // full-rate travel at the largest deltas
      set_gains(16'd256, 16'd16, 16'd128, 16'd3000, 16'hFFFF);
      for (int i = 0; i < WRAP_TICKS; i++) begin
         while (tick_queue.size() >= 64) @(negedge clock);
         push_wrap_tick();
      end
      wait_idle();

      // let any stray beat show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
